### sv/b24r565_pkg.sv
// Shared constants, status codes and types of the BMP24 to RGB565 stream block.
// No dependencies; every other file imports this package.
`default_nettype none

package b24r565_pkg;

  // Largest image side accepted, independent of the screen registers
  localparam int MAX_DIM   = 1024;
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int CFG_W     = 11;
  localparam int IMG_W     = (DIM_W > CFG_W) ? DIM_W : CFG_W;
  localparam int CRD_W     = 10;
  localparam int COLOR_W   = 16;
  localparam int STAT_W    = 3;
  localparam int CFG_IDX_W = 1;

  // Header layout (byte positions in the file)
  localparam int HDR_LEN    = 54;
  localparam int POS_OFFSET = 10;
  localparam int POS_WIDTH  = 18;
  localparam int POS_HEIGHT = 22;
  localparam int POS_DEPTH  = 28;
  localparam int POS_LAST   = HDR_LEN - 1;

  localparam logic [7:0]  SIG_B  = 8'h42;
  localparam logic [7:0]  SIG_M  = 8'h4D;
  localparam logic [15:0] BPP_24 = 16'd24;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_PIXEL   = 3'd0;
  localparam logic [STAT_W-1:0] ST_SIG     = 3'd1;
  localparam logic [STAT_W-1:0] ST_DEPTH   = 3'd2;
  localparam logic [STAT_W-1:0] ST_LARGE   = 3'd3;
  localparam logic [STAT_W-1:0] ST_TRUNC   = 3'd4;
  localparam logic [STAT_W-1:0] ST_BADSIZE = 3'd5;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0]     CFG_WIDTH_RST  = 11'd320;
  localparam logic [CFG_W-1:0]     CFG_HEIGHT_RST = 11'd240;

  // Queue between parser and output stage (power of two)
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [CFG_W-1:0] max_width;
    logic [CFG_W-1:0] max_height;
  } cfg_t;

  // One classified result on its way to the output stage
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CRD_W-1:0]  px;
    logic [CRD_W-1:0]  py;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              last;
    logic [CFG_W-1:0]  img_w;
    logic [CFG_W-1:0]  img_h;
  } tok_t;

endpackage

`default_nettype wire

### sv/b24r565_if.sv
// Handshake interfaces of the byte input channel and the pixel result channel.
// Depends on b24r565_pkg for the field widths.
`default_nettype none

interface b24r565_in_if import b24r565_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       final_byte;

  modport source (output valid, data_byte, first_byte, final_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, final_byte, output ready);
endinterface

interface b24r565_out_if import b24r565_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [CRD_W-1:0]   pixel_x;
  logic [CRD_W-1:0]   pixel_y;
  logic [CRD_W-1:0]   screen_x;
  logic [CRD_W-1:0]   screen_y;
  logic [COLOR_W-1:0] color;
  logic               last_pixel;

  modport source (output valid, status, pixel_x, pixel_y, screen_x, screen_y, color,
                  last_pixel, input ready);
  modport sink   (input valid, status, pixel_x, pixel_y, screen_x, screen_y, color,
                  last_pixel, output ready);
endinterface

`default_nettype wire

### sv/b24r565_front.sv
// Parser front end: takes file bytes, walks header, skip, pixel and pad phases,
// and pushes one classified item per pixel or error. Uses b24r565_pkg, b24r565_if.
`default_nettype none

module b24r565_front import b24r565_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  b24r565_in_if.sink     in_bus,
  input  cfg_t           cfg,
  input  logic           q_full,
  output logic           q_push,
  output tok_t           q_tok
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_SKIP   = 3'd1;
  localparam logic [2:0] PH_PIXEL  = 3'd2;
  localparam logic [2:0] PH_PAD    = 3'd3;
  localparam logic [2:0] PH_IDLE   = 3'd4;

  logic             accept;
  logic [2:0]       phase_r, phase_nxt;
  logic [31:0]      pos_r, pos_nxt;
  logic [31:0]      offset_r, offset_nxt;
  logic [31:0]      width_r, width_nxt;
  logic [31:0]      height_r, height_nxt;
  logic [15:0]      depth_r, depth_nxt;
  logic [IMG_W-1:0] col_r, col_nxt;
  logic [IMG_W-1:0] rows_r, rows_nxt;
  logic [1:0]       comp_r, comp_nxt;
  logic [1:0]       pad_r, pad_nxt;
  logic [7:0]       blue_r, blue_nxt;
  logic [7:0]       green_r, green_nxt;

  logic [STAT_W-1:0] hdr_code;
  logic              w_big, h_big, w_bad, h_bad;

  assign in_bus.ready = !q_full;
  assign accept       = in_bus.valid & in_bus.ready;

  // Header checks on the gathered fields, in priority order
  always_comb begin
    w_big = !width_r[31] && ((width_r[30:0] > 31'(cfg.max_width)) ||
                             (width_r[30:0] > 31'(MAX_DIM)));
    h_big = !height_r[31] && ((height_r[30:0] > 31'(cfg.max_height)) ||
                              (height_r[30:0] > 31'(MAX_DIM)));
    w_bad = width_r[31] || (width_r == '0);
    h_bad = height_r[31] || (height_r == '0);
    priority if (depth_r != BPP_24)            hdr_code = ST_DEPTH;
    else if (w_big || h_big)                  hdr_code = ST_LARGE;
    else if (w_bad || h_bad)                  hdr_code = ST_BADSIZE;
    else if (offset_r < 32'(HDR_LEN))         hdr_code = ST_BADSIZE;
    else                                      hdr_code = ST_PIXEL;
  end

  always_comb begin
    logic [2:0]       cur_phase;
    logic [31:0]      cur_pos;
    logic [7:0]       b;
    logic             fin;
    logic             push_c;
    logic [1:0]       lane;
    logic [IMG_W-1:0] col_inc;
    logic [IMG_W-1:0] rows_dec;
    logic [IMG_W-1:0] rows_after;
    logic             wrap;
    logic             last;
    tok_t             tok;

    b         = in_bus.data_byte;
    fin       = in_bus.final_byte;
    cur_phase = in_bus.first_byte ? PH_HEADER : phase_r;
    cur_pos   = in_bus.first_byte ? '0 : pos_r;

    phase_nxt  = cur_phase;
    pos_nxt    = cur_pos;
    offset_nxt = offset_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    depth_nxt  = depth_r;
    col_nxt    = col_r;
    rows_nxt   = rows_r;
    comp_nxt   = comp_r;
    pad_nxt    = pad_r;
    blue_nxt   = blue_r;
    green_nxt  = green_r;
    push_c     = 1'b0;
    tok        = '0;
    lane       = '0;
    col_inc    = col_r + IMG_W'(1);
    rows_dec   = rows_r - IMG_W'(1);
    wrap       = (col_inc == width_r[IMG_W-1:0]);
    rows_after = wrap ? rows_dec : rows_r;
    last       = (rows_after == '0);

    unique case (cur_phase)
      PH_HEADER: begin
        pos_nxt = cur_pos + 32'd1;
        if ((cur_pos == 32'd0 && b != SIG_B) || (cur_pos == 32'd1 && b != SIG_M)) begin
          push_c     = 1'b1;
          tok.status = ST_SIG;
          phase_nxt  = PH_IDLE;
        end else begin
          if (cur_pos >= 32'(POS_OFFSET) && cur_pos < 32'(POS_OFFSET + 4)) begin
            lane = 2'(cur_pos - 32'(POS_OFFSET));
            offset_nxt[{lane, 3'b000} +: 8] = b;
          end
          if (cur_pos >= 32'(POS_WIDTH) && cur_pos < 32'(POS_WIDTH + 4)) begin
            lane = 2'(cur_pos - 32'(POS_WIDTH));
            width_nxt[{lane, 3'b000} +: 8] = b;
          end
          if (cur_pos >= 32'(POS_HEIGHT) && cur_pos < 32'(POS_HEIGHT + 4)) begin
            lane = 2'(cur_pos - 32'(POS_HEIGHT));
            height_nxt[{lane, 3'b000} +: 8] = b;
          end
          if (cur_pos == 32'(POS_DEPTH))     depth_nxt[7:0]  = b;
          if (cur_pos == 32'(POS_DEPTH + 1)) depth_nxt[15:8] = b;
          if (cur_pos == 32'(POS_LAST) && hdr_code != ST_PIXEL) begin
            push_c     = 1'b1;
            tok.status = hdr_code;
            phase_nxt  = PH_IDLE;
          end else begin
            if (cur_pos == 32'(POS_LAST)) begin
              rows_nxt  = height_r[IMG_W-1:0];
              col_nxt   = '0;
              comp_nxt  = '0;
              phase_nxt = (offset_r == 32'(HDR_LEN)) ? PH_PIXEL : PH_SKIP;
            end
            if (fin) begin
              push_c     = 1'b1;
              tok.status = ST_TRUNC;
              phase_nxt  = PH_IDLE;
            end
          end
        end
      end
      PH_SKIP: begin
        pos_nxt = pos_r + 32'd1;
        if (pos_nxt == offset_r) phase_nxt = PH_PIXEL;
        if (fin) begin
          push_c     = 1'b1;
          tok.status = ST_TRUNC;
          phase_nxt  = PH_IDLE;
        end
      end
      PH_PIXEL: begin
        if (comp_r == 2'd0 || comp_r == 2'd1) begin
          if (comp_r == 2'd0) begin
            blue_nxt = b;
            comp_nxt = 2'd1;
          end else begin
            green_nxt = b;
            comp_nxt  = 2'd2;
          end
          if (fin) begin
            push_c     = 1'b1;
            tok.status = ST_TRUNC;
            phase_nxt  = PH_IDLE;
          end
        end else begin
          // Third byte of the triple completes a pixel
          comp_nxt = 2'd0;
          col_nxt  = wrap ? '0 : col_inc;
          rows_nxt = rows_after;
          if (wrap) begin
            pad_nxt = width_r[1:0];
            if (width_r[1:0] != 2'd0) phase_nxt = PH_PAD;
          end
          if (last) phase_nxt = PH_IDLE;
          push_c = 1'b1;
          if (fin && !last) begin
            tok.status = ST_TRUNC;
            phase_nxt  = PH_IDLE;
          end else begin
            tok.status = ST_PIXEL;
            tok.px     = col_r[CRD_W-1:0];
            tok.py     = rows_dec[CRD_W-1:0];
            tok.red    = b;
            tok.green  = green_r;
            tok.blue   = blue_r;
            tok.last   = last;
            tok.img_w  = width_r[CFG_W-1:0];
            tok.img_h  = height_r[CFG_W-1:0];
          end
        end
      end
      PH_PAD: begin
        pad_nxt = pad_r - 2'd1;
        if (pad_nxt == 2'd0) phase_nxt = PH_PIXEL;
        if (fin) begin
          push_c     = 1'b1;
          tok.status = ST_TRUNC;
          phase_nxt  = PH_IDLE;
        end
      end
      default: begin
        // Idle after an error or the last pixel: drop bytes
        phase_nxt = cur_phase;
      end
    endcase

    q_push = accept & push_c;
    q_tok  = tok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= '0;
      col_r   <= '0;
      rows_r  <= '0;
      comp_r  <= '0;
      pad_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      col_r   <= col_nxt;
      rows_r  <= rows_nxt;
      comp_r  <= comp_nxt;
      pad_r   <= pad_nxt;
    end
  end

  // Header words are fully rewritten before they are checked
  always_ff @(posedge clk) begin
    if (accept) begin
      offset_r <= offset_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      depth_r  <= depth_nxt;
      blue_r   <= blue_nxt;
      green_r  <= green_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/b24r565_queue.sv
// Short register queue of classified items between parser and output stage.
// Uses b24r565_pkg for the item type and depth.
`default_nettype none

module b24r565_queue import b24r565_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  tok_t push_tok,
  output logic full,
  input  logic pop,
  output tok_t pop_tok,
  output logic empty
);

  tok_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_tok = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_tok;
  end

endmodule

`default_nettype wire

### sv/b24r565_back.sv
// Output stage: packs RGB565, centers coordinates on the screen and holds the
// result in an output register. Uses b24r565_pkg and b24r565_if.
`default_nettype none

module b24r565_back import b24r565_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_empty,
  input  tok_t        q_tok,
  output logic        q_pop,
  b24r565_out_if.source out_bus
);

  logic               out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]  status_r;
  logic [CRD_W-1:0]   px_r, py_r, sx_r, sy_r;
  logic [COLOR_W-1:0] color_r;
  logic               last_r;

  logic [CFG_W-1:0]   diff_w, diff_h;
  logic [CRD_W-1:0]   sx_c, sy_c;
  logic [COLOR_W-1:0] color_c;
  logic               is_pix;

  assign q_pop = !q_empty && (!out_valid_r || out_bus.ready);

  always_comb begin
    is_pix  = (q_tok.status == ST_PIXEL);
    diff_w  = cfg.max_width - q_tok.img_w;
    diff_h  = cfg.max_height - q_tok.img_h;
    sx_c    = diff_w[CRD_W:1] + q_tok.px;
    sy_c    = diff_h[CRD_W:1] + q_tok.py;
    color_c = {q_tok.red[7:3], q_tok.green[7:2], q_tok.blue[7:3]};
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Error items carry zero in every field but status
  always_ff @(posedge clk) begin
    if (q_pop) begin
      status_r <= q_tok.status;
      px_r     <= is_pix ? q_tok.px : '0;
      py_r     <= is_pix ? q_tok.py : '0;
      sx_r     <= is_pix ? sx_c : '0;
      sy_r     <= is_pix ? sy_c : '0;
      color_r  <= is_pix ? color_c : '0;
      last_r   <= is_pix & q_tok.last;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.status     = status_r;
  assign out_bus.pixel_x    = px_r;
  assign out_bus.pixel_y    = py_r;
  assign out_bus.screen_x   = sx_r;
  assign out_bus.screen_y   = sy_r;
  assign out_bus.color      = color_r;
  assign out_bus.last_pixel = last_r;

endmodule

`default_nettype wire

### sv/bmp24_to_rgb565_stream.sv
// BMP24 to RGB565 stream converter, top level.
// Input channel in_bus: one file byte per item, first_byte restarts the parser,
// final_byte marks the last byte supplied. Output channel out_bus: one item per
// decoded pixel (status 0) or one error item (status 1..5) that ends the file.
// Configuration port cfg_*: index 0 sets max_width, index 1 max_height; both
// bound the accepted image size and center the image on the screen.
// Throughput: one byte per clock while in_bus.ready is high; a pixel appears
// every third pixel byte. The parser pushes each result into a two-entry queue
// at the edge that accepts the byte completing it; the output stage pops it into
// the output register once that register is empty or out_bus.ready is high.
// Reset: screen size 320 x 240, parser waits for byte 0 of a file, queue and
// output register are empty.
// Stall: while out_bus.ready is low the output register holds; the queue takes
// up to two more results, then in_bus.ready drops until an entry leaves the queue.
// Uses b24r565_pkg, b24r565_if, b24r565_front, b24r565_queue, b24r565_back.
`default_nettype none

module bmp24_to_rgb565_stream import b24r565_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  b24r565_in_if.sink           in_bus,
  b24r565_out_if.source        out_bus,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic q_push, q_full, q_pop, q_empty;
  tok_t push_tok, pop_tok;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_WIDTH:  cfg_nxt.max_width  = cfg_data;
        CFG_MAX_HEIGHT: cfg_nxt.max_height = cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_width  <= CFG_WIDTH_RST;
      cfg_r.max_height <= CFG_HEIGHT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  b24r565_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .cfg    (cfg_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_tok  (push_tok)
  );

  b24r565_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_tok (push_tok),
    .full     (q_full),
    .pop      (q_pop),
    .pop_tok  (pop_tok),
    .empty    (q_empty)
  );

  b24r565_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_empty),
    .q_tok   (pop_tok),
    .q_pop   (q_pop),
    .out_bus (out_bus)
  );

endmodule

`default_nettype wire
